// ----- rtl/core/look_at_view_matrix_top_assert.svh -----
// Assertion macros used by the checker file.
`ifndef LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH
`define LOOK_AT_VIEW_MATRIX_TOP_ASSERT_SVH

// Implication checked on every edge outside reset.
`define LAVM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the cycle after the antecedent.
`define LAVM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/core/lavm_pkg.sv -----
`timescale 1ns / 1ps
package lavm_pkg;

  localparam int FRACTION_BITS = 16;
  localparam int NORM_BITS     = 30;
  localparam int QUEUE_DEPTH   = 4;
  localparam int QUEUE_AW      = 2;
  // dividend of the unit-vector divide: shifted magnitude, fraction and rounding
  localparam int DIV_W         = NORM_BITS + FRACTION_BITS + 2;
  // unit, cross-product and row entries stay within a few bits of one
  localparam int ROW_W         = FRACTION_BITS + 4;

  typedef logic signed [ROW_W-1:0] lavm_row_t;

  // front to back record: one camera setup
  typedef struct packed {
    logic signed [31:0] eye_x;
    logic signed [31:0] eye_y;
    logic signed [31:0] eye_z;
    logic signed [32:0] fwd_x;
    logic signed [32:0] fwd_y;
    logic signed [32:0] fwd_z;
    logic signed [31:0] up_x;
    logic signed [31:0] up_y;
    logic signed [31:0] up_z;
  } lavm_item_t;

  typedef struct packed {
    logic push;
  } lavm_qctl_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_NORM,
    ST_CROSS,
    ST_ROWS
  } lavm_state_t;

  function automatic logic [63:0] mag64(input logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] round_shift(input logic signed [63:0] x);
    logic [63:0] m;
    logic [63:0] r;
    m = mag64(x);
    r = (m + (64'd1 << (FRACTION_BITS - 1))) >> FRACTION_BITS;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'h7fffffff;
    if (x < -64'sd2147483648) return 32'h80000000;
    return x[31:0];
  endfunction

endpackage

// ----- rtl/core/lavm_queue.sv -----
`timescale 1ns / 1ps
module lavm_queue (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lavm_pkg::lavm_item_t din,
  input  logic                 pop,
  output logic                 not_empty,
  output logic                 full,
  output lavm_pkg::lavm_item_t dout
);
  lavm_pkg::lavm_item_t mem_r [lavm_pkg::QUEUE_DEPTH];
  logic [lavm_pkg::QUEUE_AW-1:0] wp_r, rp_r;
  logic [lavm_pkg::QUEUE_AW:0]   cnt_r;

  assign not_empty = (cnt_r != '0);
  assign full      = (cnt_r == (lavm_pkg::QUEUE_AW+1)'(lavm_pkg::QUEUE_DEPTH));
  assign dout      = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (lavm_pkg::QUEUE_AW+1)'(push) - (lavm_pkg::QUEUE_AW+1)'(pop);
    end
  end
endmodule

// ----- rtl/core/lavm_front.sv -----
`timescale 1ns / 1ps
module lavm_front (
  input  logic                 start,
  input  logic                 q_full,
  output logic                 busy,
  input  logic signed [31:0]   in_eye_x,
  input  logic signed [31:0]   in_eye_y,
  input  logic signed [31:0]   in_eye_z,
  input  logic signed [31:0]   in_target_x,
  input  logic signed [31:0]   in_target_y,
  input  logic signed [31:0]   in_target_z,
  input  logic signed [31:0]   in_upward_x,
  input  logic signed [31:0]   in_upward_y,
  input  logic signed [31:0]   in_upward_z,
  output lavm_pkg::lavm_qctl_t qctl,
  output lavm_pkg::lavm_item_t item
);
  assign busy      = q_full;
  assign qctl.push = start && !q_full;

  // forward difference needs 33 bits
  always_comb begin
    item.eye_x = in_eye_x;
    item.eye_y = in_eye_y;
    item.eye_z = in_eye_z;
    item.fwd_x = 33'(in_target_x) - 33'(in_eye_x);
    item.fwd_y = 33'(in_target_y) - 33'(in_eye_y);
    item.fwd_z = 33'(in_target_z) - 33'(in_eye_z);
    item.up_x  = in_upward_x;
    item.up_y  = in_upward_y;
    item.up_z  = in_upward_z;
  end
endmodule

// ----- rtl/core/lavm_back.sv -----
`timescale 1ns / 1ps
module lavm_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  lavm_pkg::lavm_item_t item,
  output logic                 q_pop,
  output logic                 out_valid,
  output logic [1:0]           out_row_number,
  output logic signed [31:0]   out_entry_0,
  output logic signed [31:0]   out_entry_1,
  output logic signed [31:0]   out_entry_2,
  output logic signed [31:0]   out_entry_3,
  output logic                 out_degenerate,
  output logic                 out_last_row
);
  lavm_pkg::lavm_state_t state_r, state_nxt;

  // sequential normalizer: shared unit, one step per cycle
  logic [1:0]  vsel_r;        // 0 forward, 1 up
  logic [5:0]  step_r;
  logic [63:0] sq_x_r, sq_res_r, sq_bit_r;
  logic [31:0] s_r [3];
  logic [1:0]  ci_r;
  logic [lavm_pkg::DIV_W-1:0] div_rem_r;
  logic [lavm_pkg::DIV_W-1:0] div_q_r;
  logic [5:0]  div_cnt_r;
  logic        phase_r;       // 0 sqrt, 1 divide
  lavm_pkg::lavm_row_t fwd_r [3];
  lavm_pkg::lavm_row_t upn_r [3];
  lavm_pkg::lavm_row_t left_r [3];
  lavm_pkg::lavm_row_t tup_r [3];
  logic        degen_r;
  lavm_pkg::lavm_item_t cur_r;
  logic [1:0]  row_r;
  logic [2:0]  xs_r;

  // vector under normalization
  logic signed [63:0] v [3];
  always_comb begin
    if (vsel_r == 2'd0) begin
      v[0] = 64'(cur_r.fwd_x); v[1] = 64'(cur_r.fwd_y); v[2] = 64'(cur_r.fwd_z);
    end else begin
      v[0] = 64'(cur_r.up_x); v[1] = 64'(cur_r.up_y); v[2] = 64'(cur_r.up_z);
    end
  end

  logic [63:0] mg [3];
  logic [63:0] mmax;
  logic [6:0]  nb;
  logic [31:0] sh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) mg[i] = lavm_pkg::mag64(v[i]);
    mmax = mg[0];
    if (mg[1] > mmax) mmax = mg[1];
    if (mg[2] > mmax) mmax = mg[2];
    nb = '0;
    for (int i = 0; i < 64; i++) if (mmax[i]) nb = 7'(i + 1);
    for (int i = 0; i < 3; i++)
      sh[i] = 32'((nb > 7'(lavm_pkg::NORM_BITS)) ? mg[i] >> (nb - 7'(lavm_pkg::NORM_BITS))
                                                 : mg[i] << (7'(lavm_pkg::NORM_BITS) - nb));
  end

  // squares of the registered shifted magnitudes
  logic [63:0] sq [3];
  logic [63:0] ssum;
  always_comb begin
    for (int i = 0; i < 3; i++) sq[i] = s_r[i] * s_r[i];
    ssum = sq[0] + sq[1] + sq[2];
  end

  logic [63:0] len;
  assign len = sq_res_r;

  logic [lavm_pkg::DIV_W:0] tr;
  assign tr = {div_rem_r, div_q_r[lavm_pkg::DIV_W-1]};

  logic signed [lavm_pkg::FRACTION_BITS+1:0] qs;
  assign qs = {1'b0, div_q_r[lavm_pkg::FRACTION_BITS:0]};

  // cross product terms
  function automatic lavm_pkg::lavm_row_t xp(input lavm_pkg::lavm_row_t a1, b2, a2, b1);
    logic signed [2*lavm_pkg::ROW_W-1:0] p1, p2;
    p1 = a1 * b2;
    p2 = a2 * b1;
    return lavm_pkg::lavm_row_t'(lavm_pkg::round_shift(64'(p1) - 64'(p2)));
  endfunction

  lavm_pkg::lavm_row_t row_e [3];
  logic signed [lavm_pkg::ROW_W+31:0] pd [3];
  logic signed [63:0] dot;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      case (row_r)
        2'd0:    row_e[i] = left_r[i];
        2'd1:    row_e[i] = tup_r[i];
        default: row_e[i] = -fwd_r[i];
      endcase
    end
    pd[0] = row_e[0] * cur_r.eye_x;
    pd[1] = row_e[1] * cur_r.eye_y;
    pd[2] = row_e[2] * cur_r.eye_z;
    dot = 64'(pd[0]) + 64'(pd[1]) + 64'(pd[2]);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      lavm_pkg::ST_IDLE:  if (q_valid) state_nxt = lavm_pkg::ST_NORM;
      lavm_pkg::ST_NORM:  if (vsel_r == 2'd2) state_nxt = lavm_pkg::ST_CROSS;
      lavm_pkg::ST_CROSS: if (xs_r == 3'd1) state_nxt = lavm_pkg::ST_ROWS;
      lavm_pkg::ST_ROWS:  if (row_r == 2'd3) state_nxt = lavm_pkg::ST_IDLE;
      default:            state_nxt = lavm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    q_pop = (state_r == lavm_pkg::ST_IDLE) && q_valid;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= lavm_pkg::ST_IDLE;
      out_valid <= 1'b0;
      vsel_r <= '0; step_r <= '0; phase_r <= 1'b0; row_r <= '0; xs_r <= '0;
      ci_r <= '0; div_cnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      out_valid <= 1'b0;
      unique case (state_r)
        lavm_pkg::ST_IDLE: if (q_valid) begin
          cur_r <= item; vsel_r <= '0; step_r <= '0; phase_r <= 1'b0;
          degen_r <= 1'b0;
        end
        lavm_pkg::ST_NORM: begin
          if (step_r == 6'd0) begin
            if (mmax == '0) begin
              for (int i = 0; i < 3; i++)
                if (vsel_r == 2'd0) fwd_r[i] <= '0; else upn_r[i] <= '0;
              degen_r <= 1'b1;
              vsel_r <= vsel_r + 1'b1;
            end else begin
              for (int i = 0; i < 3; i++) s_r[i] <= sh[i];
              step_r <= 6'd1;
            end
          end else if (step_r == 6'd1) begin
            sq_x_r <= ssum; sq_res_r <= '0; sq_bit_r <= 64'd1 << 62;
            step_r <= 6'd2; phase_r <= 1'b0;
          end else if (!phase_r) begin
            // one radix-4 square-root step per cycle
            if (sq_bit_r == '0) begin
              phase_r <= 1'b1; ci_r <= '0; div_cnt_r <= '0;
              div_rem_r <= '0;
              div_q_r <= (lavm_pkg::DIV_W'(s_r[0]) << lavm_pkg::FRACTION_BITS)
                       + lavm_pkg::DIV_W'(len >> 1);
            end else if (sq_x_r >= sq_res_r + sq_bit_r) begin
              sq_x_r <= sq_x_r - (sq_res_r + sq_bit_r);
              sq_res_r <= (sq_res_r >> 1) + sq_bit_r;
              sq_bit_r <= sq_bit_r >> 2;
            end else begin
              sq_res_r <= sq_res_r >> 1;
              sq_bit_r <= sq_bit_r >> 2;
            end
          end else begin
            // restoring divide, one quotient bit per cycle
            if (div_cnt_r == 6'(lavm_pkg::DIV_W)) begin
              if (vsel_r == 2'd0)
                fwd_r[ci_r] <= lavm_pkg::lavm_row_t'(v[ci_r][63] ? -qs : qs);
              else
                upn_r[ci_r] <= lavm_pkg::lavm_row_t'(v[ci_r][63] ? -qs : qs);
              if (ci_r == 2'd2) begin
                vsel_r <= vsel_r + 1'b1; step_r <= '0;
              end else begin
                ci_r <= ci_r + 1'b1; div_cnt_r <= '0; div_rem_r <= '0;
                div_q_r <= (lavm_pkg::DIV_W'(s_r[ci_r + 1'b1]) << lavm_pkg::FRACTION_BITS)
                         + lavm_pkg::DIV_W'(len >> 1);
              end
            end else begin
              if (tr >= (lavm_pkg::DIV_W+1)'(len)) begin
                div_rem_r <= lavm_pkg::DIV_W'(tr - (lavm_pkg::DIV_W+1)'(len));
                div_q_r <= {div_q_r[lavm_pkg::DIV_W-2:0], 1'b1};
              end else begin
                div_rem_r <= tr[lavm_pkg::DIV_W-1:0];
                div_q_r <= {div_q_r[lavm_pkg::DIV_W-2:0], 1'b0};
              end
              div_cnt_r <= div_cnt_r + 1'b1;
            end
          end
          if (vsel_r == 2'd2) xs_r <= '0;
        end
        lavm_pkg::ST_CROSS: begin
          if (xs_r == 3'd0) begin
            left_r[0] <= xp(fwd_r[1], upn_r[2], fwd_r[2], upn_r[1]);
            left_r[1] <= xp(fwd_r[2], upn_r[0], fwd_r[0], upn_r[2]);
            left_r[2] <= xp(fwd_r[0], upn_r[1], fwd_r[1], upn_r[0]);
            xs_r <= 3'd1;
          end else begin
            tup_r[0] <= xp(left_r[1], fwd_r[2], left_r[2], fwd_r[1]);
            tup_r[1] <= xp(left_r[2], fwd_r[0], left_r[0], fwd_r[2]);
            tup_r[2] <= xp(left_r[0], fwd_r[1], left_r[1], fwd_r[0]);
            row_r <= '0;
          end
        end
        lavm_pkg::ST_ROWS: begin
          out_valid <= 1'b1;
          out_row_number <= row_r;
          out_degenerate <= degen_r;
          out_last_row <= (row_r == 2'd3);
          if (row_r == 2'd3) begin
            out_entry_0 <= '0; out_entry_1 <= '0; out_entry_2 <= '0;
            out_entry_3 <= lavm_pkg::sat32(64'sd1 <<< lavm_pkg::FRACTION_BITS);
          end else begin
            out_entry_0 <= lavm_pkg::sat32(64'(row_e[0]));
            out_entry_1 <= lavm_pkg::sat32(64'(row_e[1]));
            out_entry_2 <= lavm_pkg::sat32(64'(row_e[2]));
            out_entry_3 <= lavm_pkg::sat32(-lavm_pkg::round_shift(dot));
          end
          row_r <= row_r + 1'b1;
        end
        default: ;
      endcase
    end
  end
endmodule

// ----- rtl/core/look_at_view_matrix_top.sv -----
`timescale 1ns / 1ps
// channel   | ports                                   | handshake
// input     | in_eye_*, in_target_*, in_upward_*      | start & !busy
// result    | out_row_number, out_entry_*, flags      | out_valid per row beat
// Each item holds the back end: a pop, then per nonzero vector a reduce step,
// a square step, the root steps and three serial divides, then the normalizer exit,
// the cross-product steps and the row steps; a zero vector skips the root and divides.
// New items wait in a four-deep queue while the serial sqrt/divide unit works.
// busy rises only when the queue is full. Reset is synchronous, active low.
// The four rows leave on consecutive cycles; the receiver cannot stall results.
module look_at_view_matrix_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic signed [31:0] in_eye_x,
  input  logic signed [31:0] in_eye_y,
  input  logic signed [31:0] in_eye_z,
  input  logic signed [31:0] in_target_x,
  input  logic signed [31:0] in_target_y,
  input  logic signed [31:0] in_target_z,
  input  logic signed [31:0] in_upward_x,
  input  logic signed [31:0] in_upward_y,
  input  logic signed [31:0] in_upward_z,
  output logic               out_valid,
  output logic [1:0]         out_row_number,
  output logic signed [31:0] out_entry_0,
  output logic signed [31:0] out_entry_1,
  output logic signed [31:0] out_entry_2,
  output logic signed [31:0] out_entry_3,
  output logic               out_degenerate,
  output logic               out_last_row
);
  lavm_pkg::lavm_qctl_t qctl;
  lavm_pkg::lavm_item_t fitem, bitem;
  logic q_full, q_ne, q_pop;

  lavm_front u_front (
    .start, .q_full, .busy,
    .in_eye_x, .in_eye_y, .in_eye_z, .in_target_x, .in_target_y, .in_target_z,
    .in_upward_x, .in_upward_y, .in_upward_z, .qctl, .item(fitem)
  );

  lavm_queue u_queue (
    .clk, .rst_n, .push(qctl.push), .din(fitem), .pop(q_pop),
    .not_empty(q_ne), .full(q_full), .dout(bitem)
  );

  lavm_back u_back (
    .clk, .rst_n, .q_valid(q_ne), .item(bitem), .q_pop,
    .out_valid, .out_row_number, .out_entry_0, .out_entry_1, .out_entry_2,
    .out_entry_3, .out_degenerate, .out_last_row
  );
endmodule

// ----- rtl/core/lavm_checker.sv -----
`timescale 1ns / 1ps
`include "look_at_view_matrix_top_assert.svh"
module lavm_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic [1:0] out_row_number,
  input logic       out_last_row,
  input logic       out_degenerate
);
  `LAVM_ASSERT_IMP(a_last_row, clk, rst_n, out_valid, out_last_row == (out_row_number == 2'd3))
  `LAVM_ASSERT_NXT(a_row_seq, clk, rst_n, out_valid && !out_last_row, out_valid && out_row_number == $past(out_row_number) + 2'd1)
  `LAVM_ASSERT_NXT(a_degen_hold, clk, rst_n, out_valid && !out_last_row, out_degenerate == $past(out_degenerate))
endmodule

bind look_at_view_matrix_top lavm_checker u_lavm_checker (
  .clk, .rst_n, .out_valid, .out_row_number, .out_last_row, .out_degenerate
);

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  localparam int FB = 16;
  localparam int N_RANDOM = 310;
  localparam int IDLE_LIMIT = 20000;

  // how the expected rows of a setup are found
  localparam int K_PREDICT  = 0;
  localparam int K_IDENTITY = 1;
  localparam int K_NULL     = 2;

  typedef struct {
    logic signed [31:0] v[9];
    int                 kind;
  } cam_setup_t;

  typedef struct {
    logic [1:0]         row;
    logic signed [31:0] e[4];
    logic               degen;
    logic               last;
  } view_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic signed [31:0] in_f[9];
  logic out_valid;
  logic [1:0] out_row_number;
  logic signed [31:0] out_entry_0, out_entry_1, out_entry_2, out_entry_3;
  logic out_degenerate, out_last_row;

  view_row_t rows_pending[$];
  int mismatches = 0;
  int idle_cycles = 0;
  bit timed_out = 0;

  initial for (int i = 0; i < 9; i++) in_f[i] = '0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  look_at_view_matrix_top u_top (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_eye_x(in_f[0]), .in_eye_y(in_f[1]), .in_eye_z(in_f[2]),
    .in_target_x(in_f[3]), .in_target_y(in_f[4]), .in_target_z(in_f[5]),
    .in_upward_x(in_f[6]), .in_upward_y(in_f[7]), .in_upward_z(in_f[8]),
    .out_valid(out_valid), .out_row_number(out_row_number),
    .out_entry_0(out_entry_0), .out_entry_1(out_entry_1),
    .out_entry_2(out_entry_2), .out_entry_3(out_entry_3),
    .out_degenerate(out_degenerate), .out_last_row(out_last_row)
  );

  function automatic logic [63:0] abs64(logic signed [63:0] x);
    return x[63] ? 64'(-x) : 64'(x);
  endfunction

  function automatic logic signed [63:0] rnd_q(logic signed [63:0] x);
    logic [63:0] r;
    r = (abs64(x) + (64'd1 << (FB - 1))) >> FB;
    return x[63] ? -$signed(r) : $signed(r);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7fffffff;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic [63:0] root64(logic [63:0] x);
    logic [63:0] res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else res >>= 1;
      b >>= 2;
    end
    return res;
  endfunction

  // returns 1 on zero length
  function automatic bit unit3(input logic signed [63:0] v[3],
                               output logic signed [63:0] n[3]);
    logic [63:0] m, a, sum, len, q;
    logic [63:0] s[3];
    int nb;
    m = 0; sum = 0; nb = 0;
    for (int i = 0; i < 3; i++) if (abs64(v[i]) > m) m = abs64(v[i]);
    if (m == 0) begin
      for (int i = 0; i < 3; i++) n[i] = 0;
      return 1;
    end
    for (logic [63:0] t = m; t != 0; t >>= 1) nb++;
    for (int i = 0; i < 3; i++) begin
      a = abs64(v[i]);
      if (nb > 30) a >>= (nb - 30); else a <<= (30 - nb);
      s[i] = a;
      sum += a * a;
    end
    len = root64(sum);
    for (int i = 0; i < 3; i++) begin
      q = ((s[i] << FB) + (len >> 1)) / len;
      n[i] = v[i][63] ? -$signed(q) : $signed(q);
    end
    return 0;
  endfunction

  function automatic void cross3(input logic signed [63:0] a[3], b[3],
                                 output logic signed [63:0] c[3]);
    c[0] = rnd_q(a[1] * b[2] - a[2] * b[1]);
    c[1] = rnd_q(a[2] * b[0] - a[0] * b[2]);
    c[2] = rnd_q(a[0] * b[1] - a[1] * b[0]);
  endfunction

  task automatic predict_view(cam_setup_t c);
    logic signed [63:0] eye[3], d[3], up[3], fw[3], un[3], lf[3], tu[3], r[3][3];
    logic signed [63:0] dot;
    bit dg;
    view_row_t x;
    for (int i = 0; i < 3; i++) begin
      eye[i] = 64'(c.v[i]);
      d[i] = 64'(c.v[3+i]) - eye[i];
      up[i] = 64'(c.v[6+i]);
    end
    dg = unit3(d, fw);
    dg = unit3(up, un) | dg;
    cross3(fw, un, lf);
    cross3(lf, fw, tu);
    for (int i = 0; i < 3; i++) begin
      r[0][i] = lf[i]; r[1][i] = tu[i]; r[2][i] = -fw[i];
    end
    for (int k = 0; k < 3; k++) begin
      dot = r[k][0] * eye[0] + r[k][1] * eye[1] + r[k][2] * eye[2];
      x.row = 2'(k);
      for (int i = 0; i < 3; i++) x.e[i] = clamp32(r[k][i]);
      x.e[3] = clamp32(-rnd_q(dot));
      x.degen = dg; x.last = 0;
      rows_pending.push_back(x);
    end
    x.row = 2'd3;
    x.e[0] = 0; x.e[1] = 0; x.e[2] = 0; x.e[3] = 32'sd1 << FB;
    x.degen = dg; x.last = 1;
    rows_pending.push_back(x);
  endtask

  // diagonal orientation, no translation
  task automatic expect_diag(logic signed [31:0] d0, d1, d2, bit dg);
    view_row_t x;
    logic signed [31:0] dv[3];
    dv[0] = d0; dv[1] = d1; dv[2] = d2;
    for (int k = 0; k < 3; k++) begin
      x.row = 2'(k);
      for (int i = 0; i < 3; i++) x.e[i] = (i == k) ? dv[k] : 32'sd0;
      x.e[3] = 0;
      x.degen = dg; x.last = 0;
      rows_pending.push_back(x);
    end
    x.row = 2'd3;
    x.e[0] = 0; x.e[1] = 0; x.e[2] = 0; x.e[3] = 32'sh00010000;
    x.degen = dg; x.last = 1;
    rows_pending.push_back(x);
  endtask

  always @(posedge clk) begin
    view_row_t x;
    if (rst_n && out_valid) begin
      if (rows_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected row beat %0d", out_row_number);
      end else begin
        x = rows_pending.pop_front();
        if (x.row !== out_row_number || x.e[0] !== out_entry_0 ||
            x.e[1] !== out_entry_1 || x.e[2] !== out_entry_2 ||
            x.e[3] !== out_entry_3 || x.degen !== out_degenerate ||
            x.last !== out_last_row) begin
          mismatches++;
          if (mismatches <= 10)
            $display("row exp %0d %h %h %h %h d%b l%b got %0d %h %h %h %h d%b l%b",
              x.row, x.e[0], x.e[1], x.e[2], x.e[3], x.degen, x.last,
              out_row_number, out_entry_0, out_entry_1, out_entry_2, out_entry_3,
              out_degenerate, out_last_row);
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT && !timed_out) begin
      timed_out = 1;
      $display("look_at_view_matrix_top: mismatch");
      $finish;
    end
  end

  function automatic logic signed [31:0] rand_coord(int mode);
    case (mode)
      0: return $signed($urandom);
      1: return $signed($urandom_range(0, 32'h000fffff)) - 32'sh00080000;
      2: return $signed($urandom_range(0, 255)) - 128;
      default: begin
        case ($urandom_range(0, 3))
          0: return 32'sh7fffffff;
          1: return 32'sh80000000;
          2: return 0;
          default: return 32'sh00010000;
        endcase
      end
    endcase
  endfunction

  task automatic send_setup(cam_setup_t c, bit gaps);
    int g;
    if (gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      g = $urandom_range(1, 13);
      repeat (g) @(posedge clk);
    end
    for (int i = 0; i < 9; i++) in_f[i] <= c.v[i];
    start <= 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    case (c.kind)
      K_IDENTITY: expect_diag(32'sh00010000, 32'sh00010000, 32'sh00010000, 1'b0);
      K_NULL:     expect_diag(32'sd0, 32'sd0, 32'sd0, 1'b1);
      default:    predict_view(c);
    endcase
  endtask

  initial begin
    cam_setup_t c;
    cam_setup_t dir[$];
    int md;
    int drain;
    logic signed [31:0] mx, mn, one;
    mx = 32'sh7fffffff; mn = 32'sh80000000; one = 32'sh00010000;
    // eye, target, up
    dir.push_back('{v: '{0, 0, 0, 0, 0, -one, 0, one, 0}, kind: K_IDENTITY});
    dir.push_back('{v: '{one, 2*one, 3*one, 0, 0, 0, 0, one, 0}, kind: K_PREDICT});
    dir.push_back('{v: '{0, 0, 0, 0, 0, 0, 0, one, 0}, kind: K_NULL});      // zero forward
    dir.push_back('{v: '{0, 0, 0, one, 0, 0, 0, 0, 0}, kind: K_PREDICT});   // zero up
    dir.push_back('{v: '{5, 5, 5, 5, 5, 5, 0, 0, 0}, kind: K_NULL});        // both zero
    dir.push_back('{v: '{0, 0, 0, 0, one, 0, 0, 3*one, 0}, kind: K_PREDICT});  // parallel
    dir.push_back('{v: '{0, 0, 0, 0, -one, 0, 0, one, 0}, kind: K_PREDICT});   // antiparallel
    dir.push_back('{v: '{mn, mn, mn, mx, mx, mx, mx, mx, mx}, kind: K_PREDICT});
    dir.push_back('{v: '{mx, mx, mx, mn, mn, mn, mn, mn, mn}, kind: K_PREDICT});
    dir.push_back('{v: '{mx, mn, mx, mn, mx, mn, mx, 0, mn}, kind: K_PREDICT});
    dir.push_back('{v: '{mx, mx, mx, 0, 0, 0, 0, one, 0}, kind: K_PREDICT});
    dir.push_back('{v: '{mn, 0, 0, mx, 0, 0, 0, 0, mn}, kind: K_PREDICT});
    dir.push_back('{v: '{0, 0, 0, 1, 0, 0, 0, 1, 0}, kind: K_PREDICT});
    dir.push_back('{v: '{-1, -1, -1, 0, 0, 0, 1, 1, 1}, kind: K_PREDICT});
    dir.push_back('{v: '{mx, 0, mn, 0, mx, 0, -1, mx, -1}, kind: K_PREDICT});
    dir.push_back('{v: '{3*one, one, -7*one, -one, 4*one, 2*one, one, one, 0},
                    kind: K_PREDICT});
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir[i]) send_setup(dir[i], 1);
    for (int n = 0; n < N_RANDOM; n++) begin
      md = $urandom_range(0, 3);
      c.kind = K_PREDICT;
      for (int i = 0; i < 9; i++) c.v[i] = rand_coord(md);
      // sometimes reuse eye as target or zero the up vector
      if ($urandom_range(0, 15) == 0) for (int i = 0; i < 3; i++) c.v[3+i] = c.v[i];
      if ($urandom_range(0, 15) == 0) for (int i = 6; i < 9; i++) c.v[i] = 0;
      send_setup(c, n < N_RANDOM - 40);
    end
    start <= 1'b0;
    drain = 0;
    while (rows_pending.size() != 0 && drain < 200000) begin
      @(posedge clk);
      drain++;
    end
    repeat (50) @(posedge clk);
    if (mismatches == 0 && rows_pending.size() == 0)
      $display("look_at_view_matrix_top: match");
    else
      $display("look_at_view_matrix_top: mismatch");
    $finish;
  end

endmodule

// ----- look_at_view_matrix_top.f -----
+incdir+rtl/core
rtl/core/lavm_pkg.sv
rtl/core/lavm_queue.sv
rtl/core/lavm_front.sv
rtl/core/lavm_back.sv
rtl/core/look_at_view_matrix_top.sv
rtl/core/lavm_checker.sv
tb/sv/tb_top.sv
